FILE: src/alf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alf_pkg: assembler lexer shared types and constants
// Scan modes, token kinds, item events, status codes, character constants
// and the result item layout.
// ----------------------------------------------------------------------------
package alf_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int CAP_BITS       = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = '1;
  localparam logic [1:0] LIT_MAX = 2'd3;
  localparam logic [1:0] LIT_ONE = 2'd1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_INT    = 3'd2,
    MODE_CHAR   = 3'd3,
    MODE_STRING = 3'd4,
    MODE_STAR   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_INT    = 4'd1,
    KIND_CHAR   = 4'd2,
    KIND_STRING = 4'd3,
    KIND_STAR   = 4'd4,
    KIND_EOL    = 4'd5,
    KIND_EOP    = 4'd6,
    KIND_COMMA  = 4'd7,
    KIND_COLON  = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_START  = 2'd1,
    EV_EXTEND = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_INVAL  = 3'd1,
    ST_CHAR   = 3'd2,
    ST_STRING = 3'd3,
    ST_FULL   = 3'd4,
    ST_NOTERM = 3'd5
  } status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  typedef struct packed {
    logic [1:0]  token_event;
    logic [3:0]  token_kind;
    logic [15:0] token_index;
    logic [15:0] byte_position;
    logic        line_done;
    logic [2:0]  status_code;
  } result_t;

endpackage
`default_nettype wire

FILE: src/alf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alf_if: assembler lexer channel interfaces
// Source byte channel, token result channel and capacity write channel.
// ----------------------------------------------------------------------------
interface alf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       last_byte;

  modport source (output valid, output src_byte, output last_byte, input ready);
  modport sink (input valid, input src_byte, input last_byte, output ready);
endinterface

interface alf_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_event;
  logic [3:0]  token_kind;
  logic [15:0] token_index;
  logic [15:0] byte_position;
  logic        line_done;
  logic [2:0]  status_code;

  modport source (output valid, output token_event, output token_kind,
                  output token_index, output byte_position, output line_done,
                  output status_code, input ready);
  modport sink (input valid, input token_event, input token_kind,
                input token_index, input byte_position, input line_done,
                input status_code, output ready);
endinterface

interface alf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] token_capacity;

  modport source (output valid, output token_capacity, input ready);
  modport sink (input valid, input token_capacity, output ready);
endinterface
`default_nettype wire

FILE: src/alf_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alf_fsm: lexer scan state machine
// Holds scan mode, literal length, token count, source offset and the
// latched error; decides one byte per accepted item.
// ----------------------------------------------------------------------------
module alf_fsm #(
  parameter int INDEX_BITS = alf_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [7:0]                    src_byte,
  input  logic                          last_byte,
  input  logic [alf_pkg::CAP_BITS-1:0]  capacity,
  output alf_pkg::result_t              result
);
  import alf_pkg::*;

  localparam int CW = (INDEX_BITS > CAP_BITS) ? INDEX_BITS : CAP_BITS;
  localparam logic [INDEX_BITS-1:0] USED_MAX = '1;

  mode_t                 mode, mode_next;
  logic [1:0]            lit, lit_next;
  logic [INDEX_BITS-1:0] used, used_next;
  logic [15:0]           offset, offset_next;
  status_t               lerr, lerr_next;

  logic is_alpha, is_digit, is_word, is_eol;

  // idle decode
  logic  id_start, id_line, id_bad, id_litclr;
  kind_t id_kind;
  mode_t id_mode;

  // per-mode scan outcome
  event_t                s_event;
  kind_t                 s_kind;
  logic                  s_line;
  status_t               s_err;
  mode_t                 s_mode;
  logic [1:0]            s_lit;
  logic [INDEX_BITS-1:0] s_idx, s_used;
  logic                  use_idle;

  logic          full;
  logic [CW-1:0] idx_w;

  assign is_alpha = (src_byte inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]});
  assign is_digit = (src_byte inside {[CH_DIG_0:CH_DIG_9]});
  assign is_word  = is_alpha || is_digit || (src_byte == CH_USCORE);
  assign is_eol   = (src_byte == CH_NL) || (src_byte == CH_NUL);

  assign full = (CW'(used) >= CW'(capacity)) || (used == USED_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      lit    <= '0;
      used   <= '0;
      offset <= '0;
      lerr   <= ST_OK;
    end else if (fire) begin
      mode   <= mode_next;
      lit    <= lit_next;
      used   <= used_next;
      offset <= offset_next;
      lerr   <= lerr_next;
    end
  end

  always_comb begin
    id_start  = 1'b1;
    id_line   = 1'b0;
    id_bad    = 1'b0;
    id_litclr = 1'b0;
    id_kind   = KIND_IDENT;
    id_mode   = MODE_IDLE;
    case (src_byte) inside
      CH_QUOTE: begin
        id_kind   = KIND_CHAR;
        id_mode   = MODE_CHAR;
        id_litclr = 1'b1;
      end
      CH_DQUOTE: begin
        id_kind = KIND_STRING;
        id_mode = MODE_STRING;
      end
      CH_STAR: begin
        id_kind = KIND_STAR;
        id_mode = MODE_STAR;
      end
      CH_NL: begin
        id_kind = KIND_EOL;
        id_line = 1'b1;
      end
      CH_NUL: begin
        id_kind = KIND_EOP;
        id_line = 1'b1;
      end
      CH_COMMA: id_kind = KIND_COMMA;
      CH_COLON: id_kind = KIND_COLON;
      CH_SPACE: id_start = 1'b0;
      [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_USCORE: begin
        id_kind = KIND_IDENT;
        id_mode = MODE_IDENT;
      end
      [CH_DIG_0:CH_DIG_9]: begin
        id_kind = KIND_INT;
        id_mode = MODE_INT;
      end
      default: begin
        id_start = 1'b0;
        id_bad   = 1'b1;
      end
    endcase
  end

  always_comb begin
    s_event  = EV_NONE;
    s_kind   = KIND_IDENT;
    s_line   = 1'b0;
    s_err    = ST_OK;
    s_mode   = mode;
    s_lit    = lit;
    s_idx    = used - 1'b1;
    s_used   = used;
    use_idle = 1'b0;
    case (mode)
      MODE_IDENT: begin
        if (is_word) begin
          s_event = EV_EXTEND;
          s_kind  = KIND_IDENT;
        end else begin
          use_idle = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          s_event = EV_EXTEND;
          s_kind  = KIND_INT;
        end else begin
          use_idle = 1'b1;
        end
      end
      MODE_STAR: begin
        if (src_byte == CH_STAR) begin
          s_event = EV_EXTEND;
          s_kind  = KIND_STAR;
        end else begin
          use_idle = 1'b1;
        end
      end
      MODE_CHAR: begin
        if (src_byte == CH_QUOTE) begin
          if (lit != LIT_ONE) begin
            s_err = ST_CHAR;
          end else begin
            s_event = EV_EXTEND;
            s_kind  = KIND_CHAR;
            s_mode  = MODE_IDLE;
          end
        end else if (is_eol) begin
          s_err = ST_CHAR;
        end else begin
          if (lit != LIT_MAX) s_lit = lit + 1'b1;
          s_event = EV_EXTEND;
          s_kind  = KIND_CHAR;
        end
      end
      MODE_STRING: begin
        if (is_eol) begin
          s_err = ST_STRING;
        end else begin
          s_event = EV_EXTEND;
          s_kind  = KIND_STRING;
          if (src_byte == CH_DQUOTE) s_mode = MODE_IDLE;
        end
      end
      default: use_idle = 1'b1;
    endcase

    // run ended or idle: the byte is handled as idle in the same item
    if (use_idle) begin
      s_mode = MODE_IDLE;
      if (id_bad) begin
        s_err = ST_INVAL;
      end else if (id_start) begin
        s_event = EV_START;
        s_kind  = id_kind;
        s_line  = id_line;
        s_mode  = id_mode;
        s_idx   = used;
        s_used  = used + 1'b1;
        if (id_litclr) s_lit = '0;
      end
    end
  end

  assign idx_w = CW'(s_idx);

  always_comb begin
    mode_next   = mode;
    lit_next    = lit;
    used_next   = used;
    offset_next = offset;
    lerr_next   = lerr;
    result               = '0;
    result.byte_position = offset;
    if (lerr != ST_OK) begin
      result.status_code = lerr;
    end else if (full) begin
      result.status_code = ST_FULL;
      lerr_next          = ST_FULL;
    end else if (s_err != ST_OK) begin
      result.status_code = s_err;
      lerr_next          = s_err;
    end else begin
      mode_next          = s_mode;
      lit_next           = s_lit;
      used_next          = s_used;
      offset_next        = offset + 1'b1;
      result.token_event = s_event;
      result.line_done   = s_line;
      if (s_event != EV_NONE) begin
        result.token_kind  = s_kind;
        result.token_index = idx_w[15:0];
      end
      if (last_byte && !s_line) begin
        result.status_code = ST_NOTERM;
        lerr_next          = ST_NOTERM;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/alf_outreg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alf_outreg: token result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module alf_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  alf_pkg::result_t  d,
  output logic              free,
  alf_token_if.source       tok
);
  import alf_pkg::*;

  result_t q;
  logic    valid;

  assign free = !valid || tok.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tok.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) q <= d;
  end

  assign tok.valid         = valid;
  assign tok.token_event   = q.token_event;
  assign tok.token_kind    = q.token_kind;
  assign tok.token_index   = q.token_index;
  assign tok.byte_position = q.byte_position;
  assign tok.line_done     = q.line_done;
  assign tok.status_code   = q.status_code;

endmodule
`default_nettype wire

FILE: src/assembler_lexer_fsm_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// assembler_lexer_fsm_unit: assembler source byte lexer
// One source byte in, one token result out. Each byte is decided
// combinationally by the scan state machine and lands in the result register
// at the edge that accepts it; a new byte is taken every cycle while
// the result register is empty or being drained, so throughput is one item
// per clock while the result register is not stalled. Capacity writes are
// registered before they apply, and belong between sources.
// ----------------------------------------------------------------------------
module assembler_lexer_fsm_unit #(
  parameter int INDEX_BITS = alf_pkg::INDEX_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  alf_byte_if.sink     src,
  alf_token_if.source  tok,
  alf_cfg_if.sink      cfg
);
  import alf_pkg::*;

  logic [CAP_BITS-1:0] capacity;
  logic                free;
  logic                fire;
  result_t             result;

  assign cfg.ready = 1'b1;
  assign src.ready = free;
  assign fire      = src.valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.token_capacity;
    end
  end

  alf_fsm #(
    .INDEX_BITS (INDEX_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .src_byte  (src.src_byte),
    .last_byte (src.last_byte),
    .capacity  (capacity),
    .result    (result)
  );

  alf_outreg u_outreg (
    .clk  (clk),
    .rst  (rst),
    .load (fire),
    .d    (result),
    .free (free),
    .tok  (tok)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    src.valid && src.ready |=> tok.valid)
    else $error("accepted byte gave no result");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    tok.valid && (tok.token_event == EV_NONE) |->
      (tok.token_kind == KIND_IDENT) && (tok.token_index == '0) && !tok.line_done)
    else $error("fields set on a result with no event");

  a_line_kind: assert property (@(posedge clk) disable iff (rst)
    tok.valid && tok.line_done |->
      (tok.token_event == EV_START) &&
      ((tok.token_kind == KIND_EOL) || (tok.token_kind == KIND_EOP)))
    else $error("line done without a line end token");
`endif

endmodule
`default_nettype wire

FILE: verif/alf_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alf_token_checker: result checker for the assembler lexer
// Watches the byte, token and capacity channels, runs its own scanner
// beside the block and compares every token item field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module alf_token_checker (
  input  logic clk,
  input  logic rst,
  alf_byte_if  byte_ch,
  alf_token_if tok_ch,
  alf_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   tokens_started
);
  import alf_pkg::*;

  mode_t       scan_mode;
  logic [1:0]  lit_len;
  logic [15:0] tok_used;
  logic [15:0] src_off;
  logic [15:0] tok_cap;
  status_t     err_hold;
  result_t     due_tokens[$];

  initial begin
    fail_count     = 0;
    pending        = 0;
    tokens_started = 0;
  end

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_DIG_0 && c <= CH_DIG_9;
  endfunction

  function automatic void open_token(inout result_t r, input kind_t k);
    r.token_event = EV_START;
    r.token_kind  = k;
    r.token_index = tok_used;
    if (tok_used != 16'hFFFF) tok_used++;
  endfunction

  function automatic void grow_token(inout result_t r, input kind_t k);
    r.token_event = EV_EXTEND;
    r.token_kind  = k;
    r.token_index = tok_used - 16'd1;
  endfunction

  function automatic result_t lex_byte(input logic [7:0] c, input logic last);
    result_t r;
    status_t st;
    logic    reidle;
    r      = '0;
    st     = ST_OK;
    reidle = 1'b0;
    if (err_hold != ST_OK) begin
      r.byte_position = src_off;
      r.status_code   = err_hold;
      return r;
    end
    if (tok_used >= tok_cap || tok_used == 16'hFFFF) begin
      st = ST_FULL;
    end else begin
      case (scan_mode)
        MODE_IDENT: begin
          if (is_letter(c) || is_digit(c) || c == CH_USCORE) grow_token(r, KIND_IDENT);
          else reidle = 1'b1;
        end
        MODE_INT: begin
          if (is_digit(c)) grow_token(r, KIND_INT);
          else reidle = 1'b1;
        end
        MODE_STAR: begin
          if (c == CH_STAR) grow_token(r, KIND_STAR);
          else reidle = 1'b1;
        end
        MODE_CHAR: begin
          if (c == CH_QUOTE) begin
            if (lit_len != LIT_ONE) begin
              st = ST_CHAR;
            end else begin
              grow_token(r, KIND_CHAR);
              scan_mode = MODE_IDLE;
            end
          end else if (c == CH_NL || c == CH_NUL) begin
            st = ST_CHAR;
          end else begin
            if (lit_len < LIT_MAX) lit_len++;
            grow_token(r, KIND_CHAR);
          end
        end
        MODE_STRING: begin
          if (c == CH_NL || c == CH_NUL) begin
            st = ST_STRING;
          end else begin
            grow_token(r, KIND_STRING);
            if (c == CH_DQUOTE) scan_mode = MODE_IDLE;
          end
        end
        default: reidle = 1'b1;
      endcase
      // a byte that ends a run is taken again as a fresh idle byte
      if (reidle) begin
        scan_mode = MODE_IDLE;
        case (c)
          CH_QUOTE: begin
            lit_len   = '0;
            scan_mode = MODE_CHAR;
            open_token(r, KIND_CHAR);
          end
          CH_DQUOTE: begin
            scan_mode = MODE_STRING;
            open_token(r, KIND_STRING);
          end
          CH_STAR: begin
            scan_mode = MODE_STAR;
            open_token(r, KIND_STAR);
          end
          CH_NL: begin
            open_token(r, KIND_EOL);
            r.line_done = 1'b1;
          end
          CH_NUL: begin
            open_token(r, KIND_EOP);
            r.line_done = 1'b1;
          end
          CH_COMMA: open_token(r, KIND_COMMA);
          CH_COLON: open_token(r, KIND_COLON);
          CH_SPACE: ;
          default: begin
            if (is_letter(c) || c == CH_USCORE) begin
              scan_mode = MODE_IDENT;
              open_token(r, KIND_IDENT);
            end else if (is_digit(c)) begin
              scan_mode = MODE_INT;
              open_token(r, KIND_INT);
            end else begin
              st = ST_INVAL;
            end
          end
        endcase
      end
    end
    r.byte_position = src_off;
    if (st == ST_OK) begin
      src_off++;
      if (last && !r.line_done) st = ST_NOTERM;
    end else begin
      r.token_event = EV_NONE;
      r.token_kind  = KIND_IDENT;
      r.token_index = '0;
      r.line_done   = 1'b0;
    end
    err_hold      = st;
    r.status_code = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      scan_mode = MODE_IDLE;
      lit_len   = '0;
      tok_used  = '0;
      src_off   = '0;
      tok_cap   = CAP_RESET;
      err_hold  = ST_OK;
      due_tokens.delete();
    end else begin
      if (tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1) begin
        if (due_tokens.size() == 0) begin
          $error("token item with no source byte pending");
          fail_count++;
        end else begin
          want = due_tokens.pop_front();
          check_field("token_event", want.token_event, tok_ch.token_event);
          check_field("token_kind", want.token_kind, tok_ch.token_kind);
          check_field("token_index", want.token_index, tok_ch.token_index);
          check_field("byte_position", want.byte_position, tok_ch.byte_position);
          check_field("line_done", want.line_done, tok_ch.line_done);
          check_field("status_code", want.status_code, tok_ch.status_code);
        end
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) tok_cap = cfg_ch.token_capacity;
      if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
        due_tokens.push_back(lex_byte(byte_ch.src_byte, byte_ch.last_byte));
    end
    pending        = due_tokens.size();
    tokens_started = tok_used;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: assembler lexer testbench
// Feeds a short hand-made source and then random well-formed assembler
// lines under changing flow control and capacity settings, and ends each
// run with one randomly chosen fault, since faults hold until reset.
// ----------------------------------------------------------------------------
module tb_top;
  import alf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 275;

  logic clk;
  logic rst;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   hold_req    = 0;
  int   n_sent      = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;
  int   tokens_started;

  alf_byte_if  byte_ch ();
  alf_token_if tok_ch ();
  alf_cfg_if   cfg_ch ();

  assembler_lexer_fsm_unit i_dut (
    .clk (clk),
    .rst (rst),
    .src (byte_ch),
    .tok (tok_ch),
    .cfg (cfg_ch)
  );

  alf_token_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_ch        (byte_ch),
    .tok_ch         (tok_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_started (tokens_started)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin : token_sink
    int hold_left;
    hold_left    = 0;
    tok_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.src_byte  <= c;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (byte_ch.ready !== 1'b1) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.token_capacity <= cap;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // identifier byte; a leading one may not be a digit
  function automatic logic [7:0] word_char(input logic first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'(CH_LO_A + r);
    if (r < 52) return 8'(CH_UP_A + r - 26);
    if (r == 52) return CH_USCORE;
    return 8'(CH_DIG_0 + r - 53);
  endfunction

  // any byte that may sit inside a literal closed by delim
  function automatic logic [7:0] lit_byte(input logic [7:0] delim);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_NL || c == delim);
    return c;
  endfunction

  task automatic send_token();
    case ($urandom_range(0, 4))
      0: begin
        send_byte(word_char(1'b1), 1'b0);
        repeat ($urandom_range(0, 5)) send_byte(word_char(1'b0), 1'b0);
      end
      1: repeat ($urandom_range(1, 4)) send_byte(8'(CH_DIG_0 + $urandom_range(0, 9)), 1'b0);
      2: begin
        send_byte(CH_QUOTE, 1'b0);
        send_byte(lit_byte(CH_QUOTE), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
      end
      3: begin
        send_byte(CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) send_byte(lit_byte(CH_DQUOTE), 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
      end
      default: repeat ($urandom_range(1, 3)) send_byte(CH_STAR, 1'b0);
    endcase
  endtask

  task automatic send_line();
    repeat ($urandom_range(1, 5)) begin
      send_token();
      case ($urandom_range(0, 4))
        0: ;
        1: send_byte(CH_SPACE, 1'b0);
        2: send_byte(CH_COMMA, 1'b0);
        3: send_byte(CH_COLON, 1'b0);
        default: begin
          send_byte(CH_SPACE, 1'b0);
          send_byte(CH_SPACE, 1'b0);
        end
      endcase
    end
    send_byte(($urandom_range(0, 4) == 0) ? CH_NUL : CH_NL, $urandom_range(0, 3) == 0);
  endtask

  logic [7:0] demo_src [22] = '{
    CH_USCORE, "a", "Z", "9", CH_COLON, "0", "9", CH_COMMA,
    CH_QUOTE, 8'h7F, CH_QUOTE, CH_STAR, CH_STAR, CH_DQUOTE, 8'hFF, 8'h01,
    CH_DQUOTE, CH_SPACE, "z", CH_NL, "A", CH_NUL
  };

  initial begin : stimulus
    logic [7:0] c;
    int         phase_start;
    rst                   = 1'b1;
    byte_ch.valid         = 1'b0;
    byte_ch.src_byte      = '0;
    byte_ch.last_byte     = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.token_capacity = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_capacity(CAP_RESET);
    foreach (demo_src[i]) send_byte(demo_src[i], i == $size(demo_src) - 1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 80;
          write_capacity(CAP_RESET);
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
          write_capacity(16'($urandom_range(tokens_started + 400, 65535)));
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
          write_capacity(16'($urandom_range(tokens_started + 400, 65535)));
        end
        default: begin
          idle_pct  = 6;
          stall_pct = 6;
          write_capacity(CAP_RESET);
        end
      endcase
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_BYTES) send_line();
    end

    // one fault per run, it holds until reset
    wait_drained();
    case ($urandom_range(0, 5))
      0: begin
        send_line();
        send_token();
        do c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_NL || c == CH_QUOTE || c == CH_DQUOTE ||
               c == CH_STAR || c == CH_COMMA || c == CH_COLON || c == CH_USCORE ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_LO_A && c <= CH_LO_Z));
        send_byte(c, 1'b0);
      end
      1: begin
        send_byte(CH_QUOTE, 1'b0);
        case ($urandom_range(0, 3))
          0: send_byte(CH_QUOTE, 1'b0);
          1: begin
            send_byte(lit_byte(CH_QUOTE), 1'b0);
            send_byte(lit_byte(CH_QUOTE), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
          end
          2: begin
            send_byte(lit_byte(CH_QUOTE), 1'b0);
            send_byte(CH_NL, 1'b0);
          end
          default: send_byte(CH_NUL, 1'b0);
        endcase
      end
      2: begin
        send_byte(CH_DQUOTE, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(lit_byte(CH_DQUOTE), 1'b0);
        send_byte($urandom_range(0, 1) ? CH_NL : CH_NUL, 1'b0);
      end
      3: begin
        write_capacity(16'(tokens_started + $urandom_range(1, 4)));
        repeat (3) send_line();
      end
      4: begin
        write_capacity(16'd0);
        send_line();
      end
      default: begin
        send_line();
        send_token();
        send_byte(word_char(1'b0), 1'b1);
      end
    endcase

    wait_drained();
    write_capacity(16'd1);
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_drained();
    write_capacity(16'd0);
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_drained();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
